### hdl/rrv_pkg.sv
// package: widths, shared types and rounding helpers for the reflect/refract block
package rrv_pkg;
  localparam int W = 16;
  localparam int FRAC = W - 2;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam int SQW = W + FRAC;         // radicand width
  localparam int SRW = SQW / 2;          // root width

  typedef enum logic [0:0] {ACT_REFLECT = 1'b0, ACT_REFRACT = 1'b1} action_t;

  typedef struct packed {
    action_t                     action;
    logic signed [W-1:0]         c;
    logic signed [2:0][W-1:0]    v;
    logic signed [2:0][W-1:0]    n;
    logic [W-1:0]                eta;
  } front_item_t;

  // saturate a wide signed value to a component
  function automatic logic signed [W-1:0] sat(input logic signed [2*W+3:0] x);
    logic signed [W-1:0] r;
    if (x > $signed({{(W+4){CMAX[W-1]}}, CMAX})) r = CMAX;
    else if (x < $signed({{(W+4){CMIN[W-1]}}, CMIN})) r = CMIN;
    else r = x[W-1:0];
    return r;
  endfunction

  // round half up of a signed product scaled by 2^-k
  function automatic logic signed [2*W+3:0] rnd(input logic signed [2*W+3:0] p,
                                                 input int k);
    logic signed [2*W+3:0] t;
    t = p + ((2*W+4)'(1) <<< (k - 1));
    return t >>> k;
  endfunction
endpackage

### hdl/reflect_refract_vector.sv
// top level: reflect or refract a direction about a surface normal
// usage
//   in_ channel: action, plus dir, norm and ratio, all Q2.14 (ratio unsigned),
//   taken when in_valid and in_ready are both high
//   out_ channel: out_x/y/z Q2.14 saturated and out_total_internal,
//   one item per input item, in order, taken on out_valid and out_ready
// throughput: one item per cycle, sustained while the receiver takes results, whatever the action
// path: products, then the rounded dot product in the front, then the queue,
//   then the back pipeline, its length set by the one-bit-a-stage
//   square root pipeline
// the front and the back each stall on their own; the queue between them
//   holds up to four classified items
// when the receiver stalls, the back pipeline freezes with the result held;
//   the queue then fills and in_ready falls once the front is also full
// reset (rst_n low, synchronous) empties every stage and the queue;
//   no item is in flight afterwards
module reflect_refract_vector import rrv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic signed [W-1:0] in_dir_x,
  input  logic signed [W-1:0] in_dir_y,
  input  logic signed [W-1:0] in_dir_z,
  input  logic signed [W-1:0] in_norm_x,
  input  logic signed [W-1:0] in_norm_y,
  input  logic signed [W-1:0] in_norm_z,
  input  logic [W-1:0]        in_ratio,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic signed [W-1:0] out_z,
  output logic                out_total_internal
);
  // front to queue
  logic        f_valid, f_ready;
  front_item_t f_item;
  // queue to back
  logic        b_valid, b_ready;
  front_item_t b_item;

  rrv_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action,
    .in_dir_x, .in_dir_y, .in_dir_z, .in_norm_x, .in_norm_y, .in_norm_z,
    .in_ratio, .f_valid, .f_ready, .f_item
  );

  rrv_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  rrv_back u_back (
    .clk, .rst_n, .b_valid, .b_ready, .b_item,
    .out_valid, .out_ready, .out_x, .out_y, .out_z, .out_total_internal
  );
endmodule

### hdl/rrv_front.sv
// front: input register, dot product and action classification
module rrv_front import rrv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic signed [W-1:0] in_dir_x,
  input  logic signed [W-1:0] in_dir_y,
  input  logic signed [W-1:0] in_dir_z,
  input  logic signed [W-1:0] in_norm_x,
  input  logic signed [W-1:0] in_norm_y,
  input  logic signed [W-1:0] in_norm_z,
  input  logic [W-1:0]        in_ratio,
  output logic                f_valid,
  input  logic                f_ready,
  output front_item_t         f_item
);
  logic                     s0_valid_r;
  logic signed [2*W+3:0]    s0_p_r [3];
  front_item_t              s0_r;
  front_item_t              f_r;
  logic                     f_valid_r;
  logic                     s0_adv;
  logic                     f_adv;
  logic signed [2*W+3:0]    dsum;

  assign f_adv    = !f_valid_r || f_ready;
  assign s0_adv   = !s0_valid_r || f_adv;
  assign in_ready = s0_adv;

  // stage 0: the three products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_adv) begin
      s0_valid_r <= in_valid;
    end
    if (s0_adv && in_valid) begin
      s0_r.action <= action_t'(in_action);
      s0_r.c      <= '0;
      s0_r.v      <= {in_dir_z, in_dir_y, in_dir_x};
      s0_r.n      <= {in_norm_z, in_norm_y, in_norm_x};
      s0_r.eta    <= in_ratio;
      s0_p_r[0]   <= (2*W+4)'(in_dir_x * in_norm_x);
      s0_p_r[1]   <= (2*W+4)'(in_dir_y * in_norm_y);
      s0_p_r[2]   <= (2*W+4)'(in_dir_z * in_norm_z);
    end
  end

  assign dsum = s0_p_r[0] + s0_p_r[1] + s0_p_r[2];

  // stage 1: rounded, saturated dot product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_adv) begin
      f_valid_r <= s0_valid_r;
    end
    if (f_adv && s0_valid_r) begin
      f_r <= '{action: s0_r.action, c: sat(rnd(dsum, FRAC)), v: s0_r.v,
               n: s0_r.n, eta: s0_r.eta};
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r && !f_ready |=> f_valid_r && $stable(f_r))
    else $error("front item changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_valid_r |-> in_ready)
    else $error("front stalled while empty");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s0_valid_r)
    else $error("accepted item lost");
endmodule

### hdl/rrv_queue.sv
// queue: short fifo between front and back
module rrv_queue import rrv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  front_item_t wr_item,
  output logic        rd_valid,
  input  logic        rd_ready,
  output front_item_t rd_item
);
  front_item_t      mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r;
  logic             wr, rd;

  assign wr_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_item;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count slip");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wp_r == rp_r)
    else $error("queue pointer mismatch");
endmodule

### hdl/rrv_sqrt.sv
// pipelined integer square root, one result bit per stage
module rrv_sqrt import rrv_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQW-1:0]     x,
  output logic [SRW-1:0]     root
);
  // remainder and radicand are not carried past the last stage
  logic [SQW+1:0] rem_r  [SRW-1];
  logic [SQW-1:0] x_r    [SRW-1];
  logic [SRW-1:0] q_r    [SRW];
  logic [SQW+1:0] rem_in [SRW];
  logic [SQW-1:0] x_in   [SRW];
  logic [SRW-1:0] q_in   [SRW];
  logic [SQW+1:0] trial  [SRW];
  logic [SQW+1:0] remsh  [SRW];
  logic           take   [SRW];

  for (genvar i = 0; i < SRW; i++) begin : g_st
    if (i == 0) begin : g_first
      assign rem_in[i] = '0;
      assign x_in[i]   = x;
      assign q_in[i]   = '0;
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign x_in[i]   = x_r[i-1];
      assign q_in[i]   = q_r[i-1];
    end
    assign remsh[i] = {rem_in[i][SQW-1:0], x_in[i][SQW-1 -: 2]};
    assign trial[i] = {{(SQW-SRW){1'b0}}, q_in[i], 2'b01};
    assign take[i]  = (remsh[i] >= trial[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= {q_in[i][SRW-2:0], take[i]};
      end
    end
    if (i < SRW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i]   <= {x_in[i][SQW-3:0], 2'b00};
          rem_r[i] <= take[i] ? (remsh[i] - trial[i]) : remsh[i];
        end
      end
    end
  end

  assign root = q_r[SRW-1];
endmodule

### hdl/rrv_back.sv
// back: refraction terms, square root and result selection
module rrv_back import rrv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                b_valid,
  output logic                b_ready,
  input  front_item_t         b_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic signed [W-1:0] out_z,
  output logic                out_total_internal
);
  // pipeline: a c2 | b m | c eta*m | d p | e eta*p | f d w | sqrt stages | res (out)
  localparam int NST = 7 + SRW;
  logic                  en;
  logic [NST-1:0]        vld_r;
  front_item_t           pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [W-1:0]   m_r, p_r, dsat_r;
  logic signed [2*W+3:0] c2_r, pm_r, pp_r;
  logic                  pos_r;
  logic signed [W-1:0]   w_r [3];
  logic signed [W-1:0]   rfl_r [3];
  logic [SRW-1:0]        root;
  front_item_t           dl_r [SRW];
  logic signed [W-1:0]   wd_r [SRW][3];
  logic signed [W-1:0]   rd_r [SRW][3];
  logic                  posd_r [SRW];
  logic signed [W-1:0]   res_r [3];
  logic                  tir_r;
  logic signed [2*W+3:0] sq;
  logic [SQW-1:0]        radic;

  assign en      = !out_valid || out_ready;
  assign b_ready = en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NST-2:0], b_valid};
  end

  assign radic = SQW'({{(SQW-W){1'b0}}, dsat_r} << FRAC);
  assign sq    = (2*W+4)'(1 <<< FRAC) - rnd(pp_r, FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= b_item;
      c2_r <= (2*W+4)'(b_item.c * b_item.c);
      pb_r <= pa_r;
      m_r  <= sat((2*W+4)'(1 <<< FRAC) - rnd(c2_r, FRAC));
      pc_r <= pb_r;
      pm_r <= (2*W+4)'($signed({1'b0, pb_r.eta}) * m_r);
      pd_r <= pc_r;
      p_r  <= sat(rnd(pm_r, FRAC));
      pe_r <= pd_r;
      pp_r <= (2*W+4)'($signed({1'b0, pd_r.eta}) * p_r);
      // stage f: d, its sign, w and reflect terms
      pf_r   <= pe_r;
      pos_r  <= sq > 0;
      dsat_r <= (sq > 0) ? sat(sq) : '0;
      for (int i = 0; i < 3; i++) begin
        w_r[i]   <= sat((2*W+4)'($signed(pe_r.v[i])) -
                        rnd((2*W+4)'(pe_r.c * $signed(pe_r.n[i])), FRAC));
        rfl_r[i] <= sat((2*W+4)'($signed(pe_r.v[i])) -
                        rnd((2*W+4)'(pe_r.c * $signed(pe_r.n[i])), FRAC - 1));
      end
      // delay line alongside the root
      dl_r[0]   <= pf_r;
      posd_r[0] <= pos_r;
      for (int i = 0; i < 3; i++) begin
        wd_r[0][i] <= w_r[i];
        rd_r[0][i] <= rfl_r[i];
      end
      for (int s = 1; s < SRW; s++) begin
        dl_r[s] <= dl_r[s-1]; posd_r[s] <= posd_r[s-1];
        for (int i = 0; i < 3; i++) begin
          wd_r[s][i] <= wd_r[s-1][i]; rd_r[s][i] <= rd_r[s-1][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (dl_r[SRW-1].action == ACT_REFRACT && posd_r[SRW-1])
          res_r[i] <= sat(
            rnd((2*W+4)'($signed({1'b0, dl_r[SRW-1].eta}) * wd_r[SRW-1][i]), FRAC) -
            rnd((2*W+4)'($signed({1'b0, root}) * $signed(dl_r[SRW-1].n[i])), FRAC));
        else
          res_r[i] <= rd_r[SRW-1][i];
      end
      tir_r <= (dl_r[SRW-1].action == ACT_REFRACT) && !posd_r[SRW-1];
    end
  end

  rrv_sqrt u_sqrt (.clk(clk), .en(en), .x(radic), .root(root));

  assign out_x = res_r[0];
  assign out_y = res_r[1];
  assign out_z = res_r[2];
  assign out_total_internal = tir_r;

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> b_ready)
    else $error("back stalled while output empty");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r[0]))
    else $error("result changed while stalled");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid && b_ready |=> vld_r[0])
    else $error("item lost entering back");
endmodule

### dv/tb_top.sv
// testbench for reflect_refract_vector: directed table then random items, checked by a predictor
`timescale 1ns / 1ps

module tb_top;
  import rrv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [W-1:0] in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic [W-1:0] in_ratio = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] out_x, out_y, out_z;
  logic out_total_internal;

  // one ray item and one turned-ray item
  typedef struct {
    action_t act;
    logic signed [W-1:0] v [3];
    logic signed [W-1:0] n [3];
    logic [W-1:0] eta;
  } ray_t;

  typedef struct {
    logic signed [W-1:0] d [3];
    logic tir;
  } turned_t;

  // directed row: typed-in answer only where obvious
  typedef struct {
    ray_t ray;
    bit known;
    turned_t ans;
  } row_t;

  turned_t turned_q [$];
  int errors = 0;
  int cycles = 0;
  localparam int ONE = 1 << FRAC;
  localparam int LIMIT = 400000;

  reflect_refract_vector i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_norm_x(in_norm_x), .in_norm_y(in_norm_y), .in_norm_z(in_norm_z),
    .in_ratio(in_ratio),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_total_internal(out_total_internal)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clamp to the component range
  function automatic longint clamp(longint x);
    longint hi, lo;
    hi = (longint'(1) <<< (W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // round half up of a*b / 2^k
  function automatic longint rmul(longint a, longint b, int k);
    return (a * b + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint root(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // bend the ray about the normal: mirror, or snell with fallback
  function automatic turned_t bend_ray(ray_t r);
    turned_t t;
    longint c, c2, m, p, d, s, w, acc;
    bit mirror;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += longint'(r.v[i]) * longint'(r.n[i]);
    // single rounding after the exact sum
    c = clamp((acc + (ONE >> 1)) >>> FRAC);
    t.tir = 1'b0;
    mirror = (r.act == ACT_REFLECT);
    if (!mirror) begin
      c2 = rmul(c, c, FRAC);
      m = clamp(ONE - c2);
      p = clamp(rmul(longint'(r.eta), m, FRAC));
      d = ONE - rmul(longint'(r.eta), p, FRAC);
      if (d > 0) begin
        s = root(clamp(d) <<< FRAC);
        for (int i = 0; i < 3; i++) begin
          w = clamp(longint'(r.v[i]) - rmul(c, r.n[i], FRAC));
          t.d[i] = W'(clamp(rmul(longint'(r.eta), w, FRAC) - rmul(s, r.n[i], FRAC)));
        end
      end else begin
        t.tir = 1'b1;
        mirror = 1'b1;
      end
    end
    if (mirror)
      for (int i = 0; i < 3; i++)
        t.d[i] = W'(clamp(longint'(r.v[i]) - rmul(c, r.n[i], FRAC - 1)));
    return t;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic ray_t mk(action_t a, int vx, int vy, int vz,
                              int nx, int ny, int nz, int e);
    ray_t r;
    r.act = a;
    r.v[0] = W'(vx); r.v[1] = W'(vy); r.v[2] = W'(vz);
    r.n[0] = W'(nx); r.n[1] = W'(ny); r.n[2] = W'(nz);
    r.eta = W'(e);
    return r;
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    int mode;
    r.act = action_t'($urandom_range(0, 1));
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      r.v[i] = W'($urandom);
      r.n[i] = W'($urandom);
      // mostly unit-ish vectors, so refraction paths are reached
      if (mode != 0) begin
        r.v[i] = W'($signed($urandom_range(0, 2 * ONE)) - ONE);
        r.n[i] = W'($signed($urandom_range(0, 2 * ONE)) - ONE);
      end
    end
    r.eta = (mode == 3) ? W'($urandom) : W'($urandom_range(ONE / 2, 2 * ONE));
    return r;
  endfunction

  // drive one item and wait for it to be taken; valid stays up for a
  // back to back item and drops only for a gap
  task automatic send(ray_t r);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.act;
    in_dir_x <= r.v[0]; in_dir_y <= r.v[1]; in_dir_z <= r.v[2];
    in_norm_x <= r.n[0]; in_norm_y <= r.n[1]; in_norm_z <= r.n[2];
    in_ratio <= r.eta;
    do @(posedge clk); while (!in_ready);
    turned_q.push_back(bend_ray(r));
    @(negedge clk);
  endtask

  // stop offering items
  task automatic idle();
    in_valid <= 1'b0;
  endtask

  // receiver: random stalls, check against the oldest expectation
  initial begin
    int hold;
    turned_t want;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (turned_q.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          want = turned_q.pop_front();
          if (out_x !== want.d[0]) report("out_x", out_x, want.d[0]);
          if (out_y !== want.d[1]) report("out_y", out_y, want.d[1]);
          if (out_z !== want.d[2]) report("out_z", out_z, want.d[2]);
          if (out_total_internal !== want.tir)
            report("total_internal", out_total_internal, want.tir);
        end
        // some runs with no stalls at all
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero vectors reflect to zero
    rw.ray = mk(ACT_REFLECT, 0, 0, 0, 0, 0, 0, 0);
    rw.known = 1; rw.ans.d = '{0, 0, 0}; rw.ans.tir = 0;
    rows.push_back(rw);
    // straight down onto an up normal reflects straight up
    rw.ray = mk(ACT_REFLECT, 0, 0, -ONE, 0, 0, ONE, 0);
    rw.ans.d = '{0, 0, ONE}; rows.push_back(rw);
    // same with eta one refracts straight through
    rw.ray = mk(ACT_REFRACT, 0, 0, -ONE, 0, 0, ONE, ONE);
    rw.ans.d = '{0, 0, -ONE}; rows.push_back(rw);
    rw.known = 0;
    // grazing, eta two: total internal reflection
    rows.push_back('{mk(ACT_REFRACT, ONE, 0, 0, 0, 0, ONE, 2 * ONE), 0, rw.ans});
    rows.push_back('{mk(ACT_REFRACT, 11585, 0, -11585, 0, 0, ONE, 24000), 0, rw.ans});
    rows.push_back('{mk(ACT_REFRACT, 11585, 0, -11585, 0, 0, ONE, 12000), 0, rw.ans});
    // eta zero and eta max
    rows.push_back('{mk(ACT_REFRACT, 9000, -3000, -12000, 0, ONE, 0, 0), 0, rw.ans});
    rows.push_back('{mk(ACT_REFRACT, 9000, -3000, -12000, 0, ONE, 0, 65535), 0, rw.ans});
    // field extremes, saturation on both sides
    rows.push_back('{mk(ACT_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767, 0), 0, rw.ans});
    rows.push_back('{mk(ACT_REFLECT, -32768, -32768, -32768, -32768, -32768, -32768, 0),
                     0, rw.ans});
    rows.push_back('{mk(ACT_REFLECT, 32767, -32768, 32767, -32768, 32767, -32768, 65535),
                     0, rw.ans});
    rows.push_back('{mk(ACT_REFRACT, 32767, 32767, 32767, 32767, 32767, 32767, 65535),
                     0, rw.ans});
    rows.push_back('{mk(ACT_REFRACT, -32768, -32768, -32768, -32768, -32768, -32768, 65535),
                     0, rw.ans});
    rows.push_back('{mk(ACT_REFRACT, -32768, 32767, 0, 32767, 0, -32768, 1), 0, rw.ans});
    // non-unit normal
    rows.push_back('{mk(ACT_REFRACT, 5000, 6000, -7000, 3000, 2000, 9000, 20000), 0, rw.ans});

    foreach (rows[k]) begin
      if (rows[k].known) begin
        turned_t p;
        p = bend_ray(rows[k].ray);
        if (p.d[0] !== rows[k].ans.d[0] || p.d[1] !== rows[k].ans.d[1] ||
            p.d[2] !== rows[k].ans.d[2] || p.tir !== rows[k].ans.tir)
          report("directed row answer", k, 0);
      end
      send(rows[k].ray);
    end

    for (int k = 0; k < 1950; k++) begin
      // drain once midway so the pipe empties completely
      if (k == 900) begin
        idle();
        wait (turned_q.size() == 0);
        @(negedge clk);
      end
      send(rand_ray());
    end

    idle();
    wait (turned_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/rrv_pkg.sv
hdl/rrv_front.sv
hdl/rrv_queue.sv
hdl/rrv_sqrt.sv
hdl/rrv_back.sv
hdl/reflect_refract_vector.sv
dv/tb_top.sv
